[hw/rtl/lpht_pkg.sv]
// Shared constants, codes and types for the linear probe hash table.
`timescale 1ns / 1ps
package lpht_pkg;
	localparam int unsigned BUCKETS   = 256;
	localparam int unsigned IDX_W     = 8;
	localparam int unsigned CNT_W     = 9;
	localparam int unsigned KEY_W     = 32;
	localparam int unsigned HASH_W    = 32;
	localparam int unsigned IN_W      = 3 + KEY_W + HASH_W + IDX_W;
	localparam int unsigned IN_BYTES_W = ((IN_W + 7) / 8) * 8;
	localparam int unsigned OUT_W     = 3 + IDX_W + KEY_W + CNT_W;
	localparam int unsigned OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ACT_FIND     = 3'd0,
		ACT_INSERT   = 3'd1,
		ACT_REM_KEY  = 3'd2,
		ACT_GET_SLOT = 3'd3,
		ACT_REM_SLOT = 3'd4,
		ACT_FIRST    = 3'd5,
		ACT_NEXT     = 3'd6,
		ACT_NONE     = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOTFOUND = 3'd1,
		ST_PRESENT  = 3'd2,
		ST_FULL     = 3'd3,
		ST_BADSLOT  = 3'd4
	} status_t;

	// tag encoding: zero is empty, one is a tombstone, top bit set is occupied
	localparam logic [HASH_W-1:0] TAG_EMPTY = '0;
	localparam logic [HASH_W-1:0] TAG_TOMB  = {{(HASH_W-1){1'b0}}, 1'b1};
endpackage

[hw/rtl/lpht_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lpht_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

[hw/rtl/lpht_mod.sv]
// Iterative restoring reducer: low 31 hash bits modulo bucket count, one bit per cycle.
`timescale 1ns / 1ps
module lpht_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lpht_pkg::HASH_W-2:0] dividend,
	input  logic [lpht_pkg::CNT_W-1:0]  divisor,
	output logic                        done,
	output logic [lpht_pkg::IDX_W-1:0]  remainder
);
	localparam int unsigned DW = lpht_pkg::HASH_W - 1;
	localparam int unsigned CW = $clog2(DW + 1);

	logic [DW-1:0]                shift_q;
	logic [lpht_pkg::CNT_W:0]     rem_q;
	logic [CW-1:0]                cnt_q;
	logic                         busy_q;
	logic [lpht_pkg::CNT_W:0]     trial;

	assign trial = {rem_q[lpht_pkg::CNT_W-1:0], shift_q[DW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[DW-2:0], 1'b0};
			if (trial >= {1'b0, divisor})
				rem_q <= trial - {1'b0, divisor};
			else
				rem_q <= trial;
		end
	end

	assign remainder = rem_q[lpht_pkg::IDX_W-1:0];
endmodule

[hw/rtl/lpht_ctrl.sv]
// Sequencer for every table operation; key and scan operations walk buckets.
`timescale 1ns / 1ps
module lpht_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lpht_pkg::CNT_W-1:0]  cfg_data,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  lpht_pkg::action_t           req_action,
	input  logic [lpht_pkg::KEY_W-1:0]  req_key,
	input  logic [lpht_pkg::HASH_W-1:0] req_hash,
	input  logic [lpht_pkg::IDX_W-1:0]  req_slot,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output lpht_pkg::status_t           rsp_status,
	output logic [lpht_pkg::IDX_W-1:0]  rsp_slot,
	output logic [lpht_pkg::KEY_W-1:0]  rsp_key,
	output logic [lpht_pkg::CNT_W-1:0]  rsp_used
);
	localparam int unsigned IW = lpht_pkg::IDX_W;
	localparam int unsigned CW = lpht_pkg::CNT_W;
	localparam int unsigned HW = lpht_pkg::HASH_W;
	localparam int unsigned KW = lpht_pkg::KEY_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_MOD, S_RD, S_WAIT, S_CHK, S_EXT_RD, S_EXT_WAIT,
		S_EXT_CHK, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_CHK, S_KEY_RD, S_KEY_WAIT, S_RSP
	} state_t;

	state_t              state_q;
	lpht_pkg::action_t   act_q;
	logic [KW-1:0]       key_q;
	logic [HW-1:0]       tag_q;
	logic [CW-1:0]       nbk_q;
	logic [CW-1:0]       used_q;
	logic [IW-1:0]       longest_q;
	logic [IW-1:0]       idx_q;
	logic [CW-1:0]       step_q;
	logic [CW-1:0]       scan_q;
	logic                have_tomb_q;
	logic [IW-1:0]       tomb_q;
	logic [CW:0]         clr_q;

	logic                tag_we, key_we;
	logic [IW-1:0]       addr;
	logic [HW-1:0]       tag_wd, tag_rd;
	logic [KW-1:0]       key_rd;
	logic                mod_start, mod_done;
	logic [IW-1:0]       mod_rem;
	logic [IW-1:0]       idx_nx;
	logic                occ, is_empty, hit;
	logic [CW+1:0]       load_lhs, load_rhs;

	lpht_ram #(.WIDTH(HW), .DEPTH(lpht_pkg::BUCKETS)) u_tags (
		.clk(clk), .we(tag_we), .addr(addr), .wdata(tag_wd), .rdata(tag_rd));
	lpht_ram #(.WIDTH(KW), .DEPTH(lpht_pkg::BUCKETS)) u_keys (
		.clk(clk), .we(key_we), .addr(addr), .wdata(key_q), .rdata(key_rd));
	lpht_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(req_hash[HW-2:0]),
		.divisor(nbk_q), .done(mod_done), .remainder(mod_rem));

	assign idx_nx    = ({1'b0, idx_q} + 1'b1 >= nbk_q) ? '0 : idx_q + 1'b1;
	assign occ       = tag_rd[HW-1];
	assign is_empty  = tag_rd == lpht_pkg::TAG_EMPTY;
	assign hit       = (tag_rd == tag_q) && (key_rd == key_q);
	// load rule nbk >= 4*(used+1)/3 rewritten as 4*(used+1) <= 3*nbk + 2
	assign load_lhs  = {used_q, 2'b00} + (CW+2)'(4);
	assign load_rhs  = {1'b0, nbk_q, 1'b0} + {2'b00, nbk_q} + (CW+2)'(2);
	assign cfg_ready = state_q == S_IDLE;
	assign req_ready = state_q == S_IDLE && !cfg_valid;
	assign mod_start = req_valid && req_ready;

	always_comb begin
		tag_we = 1'b0;
		key_we = 1'b0;
		tag_wd = tag_q;
		addr   = idx_q;
		case (state_q)
			S_CLEAR: begin
				tag_we = 1'b1;
				tag_wd = lpht_pkg::TAG_EMPTY;
				addr   = clr_q[IW-1:0];
			end
			S_CHK: begin
				if (act_q == lpht_pkg::ACT_INSERT && is_empty) begin
					tag_we = 1'b1;
					key_we = 1'b1;
				end else if (act_q == lpht_pkg::ACT_REM_KEY && occ && hit) begin
					tag_we = 1'b1;
					tag_wd = lpht_pkg::TAG_TOMB;
				end
			end
			S_EXT_CHK: begin
				if (!occ) begin
					tag_we = 1'b1;
					key_we = 1'b1;
				end
			end
			S_KEY_RD: begin
				if (act_q == lpht_pkg::ACT_INSERT) begin
					tag_we = 1'b1;
					key_we = 1'b1;
				end
			end
			S_SCAN_CHK: begin
				if (act_q == lpht_pkg::ACT_REM_SLOT && occ) begin
					tag_we = 1'b1;
					tag_wd = lpht_pkg::TAG_TOMB;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			nbk_q       <= CW'(lpht_pkg::BUCKETS);
			used_q      <= '0;
			longest_q   <= '0;
			rsp_valid   <= 1'b0;
			act_q       <= lpht_pkg::ACT_NONE;
			have_tomb_q <= 1'b0;
		end else begin
			if (cfg_valid && state_q == S_IDLE) begin
				// clamp, then sweep every tag back to empty
				if (cfg_data == '0)
					nbk_q <= CW'(1);
				else if (cfg_data > CW'(lpht_pkg::BUCKETS))
					nbk_q <= CW'(lpht_pkg::BUCKETS);
				else
					nbk_q <= cfg_data;
				used_q    <= '0;
				longest_q <= '0;
				clr_q     <= '0;
				state_q   <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + 1'b1;
						if (clr_q == (CW+1)'(lpht_pkg::BUCKETS - 1))
							state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (req_valid) begin
							act_q       <= req_action;
							key_q       <= req_key;
							tag_q       <= {1'b1, req_hash[HW-2:0]};
							have_tomb_q <= 1'b0;
							step_q      <= '0;
							rsp_slot    <= '0;
							rsp_key     <= '0;
							rsp_status  <= lpht_pkg::ST_NOTFOUND;
							case (req_action)
								lpht_pkg::ACT_FIND, lpht_pkg::ACT_REM_KEY: begin
									if (used_q == '0)
										state_q <= S_RSP;
									else
										state_q <= S_MOD;
								end
								lpht_pkg::ACT_INSERT: begin
									if (load_lhs > load_rhs) begin
										rsp_status <= lpht_pkg::ST_FULL;
										state_q    <= S_RSP;
									end else
										state_q <= S_MOD;
								end
								lpht_pkg::ACT_GET_SLOT, lpht_pkg::ACT_REM_SLOT: begin
									idx_q <= req_slot;
									if ({1'b0, req_slot} >= nbk_q) begin
										rsp_status <= lpht_pkg::ST_BADSLOT;
										state_q    <= S_RSP;
									end else
										state_q <= S_SCAN_RD;
								end
								lpht_pkg::ACT_FIRST: begin
									scan_q <= '0;
									state_q <= (used_q == '0) ? S_RSP : S_SCAN_RD;
								end
								lpht_pkg::ACT_NEXT: begin
									scan_q  <= CW'(req_slot) + 1'b1;
									state_q <= S_SCAN_RD;
								end
								default: state_q <= S_RSP;
							endcase
						end
					end
					S_MOD: if (mod_done) begin
						idx_q   <= mod_rem;
						state_q <= S_RD;
					end
					S_RD:   state_q <= S_CHK;
					S_WAIT: state_q <= S_CHK;
					S_CHK: begin
						if (is_empty) begin
							if (act_q == lpht_pkg::ACT_INSERT) begin
								rsp_status <= lpht_pkg::ST_OK;
								rsp_slot   <= idx_q;
								rsp_key    <= key_q;
								used_q     <= used_q + 1'b1;
							end
							state_q <= S_RSP;
						end else if (tag_rd == lpht_pkg::TAG_TOMB) begin
							if (act_q == lpht_pkg::ACT_INSERT && !have_tomb_q) begin
								have_tomb_q <= 1'b1;
								tomb_q      <= idx_q;
							end
						end else if (hit) begin
							rsp_slot   <= idx_q;
							rsp_key    <= key_rd;
							rsp_status <= (act_q == lpht_pkg::ACT_INSERT) ?
								lpht_pkg::ST_PRESENT : lpht_pkg::ST_OK;
							if (act_q == lpht_pkg::ACT_REM_KEY)
								used_q <= used_q - 1'b1;
							state_q <= S_RSP;
						end
						if (!is_empty && !(hit && tag_rd != lpht_pkg::TAG_TOMB)) begin
							idx_q  <= idx_nx;
							step_q <= step_q + 1'b1;
							if (step_q == CW'(longest_q)) begin
								if (act_q != lpht_pkg::ACT_INSERT)
									state_q <= S_RSP;
								else if (have_tomb_q || tag_rd == lpht_pkg::TAG_TOMB) begin
									// reuse the first tombstone
									idx_q   <= have_tomb_q ? tomb_q : idx_q;
									state_q <= S_KEY_RD;
								end else
									state_q <= S_EXT_RD;
							end else
								state_q <= S_WAIT;
						end
					end
					S_KEY_RD: begin
						rsp_status <= lpht_pkg::ST_OK;
						rsp_slot   <= idx_q;
						rsp_key    <= key_q;
						used_q     <= used_q + 1'b1;
						state_q    <= S_RSP;
					end
					S_EXT_RD:   state_q <= S_EXT_WAIT;
					S_EXT_WAIT: state_q <= S_EXT_CHK;
					S_EXT_CHK: begin
						if (!occ) begin
							rsp_status <= lpht_pkg::ST_OK;
							rsp_slot   <= idx_q;
							rsp_key    <= key_q;
							used_q     <= used_q + 1'b1;
							longest_q  <= step_q[IW-1:0];
							state_q    <= S_RSP;
						end else begin
							idx_q   <= idx_nx;
							step_q  <= step_q + 1'b1;
							state_q <= S_EXT_RD;
						end
					end
					S_SCAN_RD: begin
						if (act_q == lpht_pkg::ACT_FIRST || act_q == lpht_pkg::ACT_NEXT) begin
							if (scan_q >= nbk_q)
								state_q <= S_RSP;
							else begin
								idx_q   <= scan_q[IW-1:0];
								state_q <= S_SCAN_WAIT;
							end
						end else
							state_q <= S_SCAN_WAIT;
					end
					S_SCAN_WAIT: state_q <= S_SCAN_CHK;
					S_SCAN_CHK: begin
						if (act_q == lpht_pkg::ACT_FIRST || act_q == lpht_pkg::ACT_NEXT) begin
							if (occ) begin
								rsp_status <= lpht_pkg::ST_OK;
								rsp_slot   <= idx_q;
								state_q    <= S_RSP;
							end else begin
								scan_q  <= scan_q + 1'b1;
								state_q <= S_SCAN_RD;
							end
						end else begin
							if (occ) begin
								rsp_status <= lpht_pkg::ST_OK;
								rsp_slot   <= idx_q;
								rsp_key    <= key_rd;
								if (act_q == lpht_pkg::ACT_REM_SLOT)
									used_q <= used_q - 1'b1;
							end else
								rsp_status <= lpht_pkg::ST_BADSLOT;
							state_q <= S_RSP;
						end
					end
					S_RSP: begin
						if (!rsp_valid)
							rsp_valid <= 1'b1;
						else if (rsp_ready) begin
							rsp_valid <= 1'b0;
							state_q   <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign rsp_used = used_q;
endmodule

[hw/rtl/linear_probe_hash_table.sv]
// Top level of the linear probing hash table.
//  channel | direction | contents
//  s_axis  | in        | tdata: action, key, hash_value, slot
//  m_axis  | out       | tdata: status, result_slot, result_key, entries_used
//  cfg     | in        | buckets_in_use
// Key operations that probe first reduce the hash to a start bucket (31-step
// serial remainder), then probe bucket by bucket; an insert that walks past
// the longest probe goes on to the next unoccupied bucket. Slot actions read
// the named bucket; first and next scan bucket by bucket. tvalid is set in the
// response state entered after the last check. Reset and every cfg write run a
// tag clearing pass over all 256 buckets; no request is taken meanwhile. The
// result holds until m_axis_tready; the next request is taken once idle again and no cfg waits.
`timescale 1ns / 1ps
module linear_probe_hash_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// action[2:0], key[34:3], hash_value[66:35], slot[74:67], zero fill
	input  logic [lpht_pkg::IN_BYTES_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// status[2:0], result_slot[10:3], result_key[42:11], entries_used[51:43], zero fill
	output logic [lpht_pkg::OUT_BYTES_W-1:0]  m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lpht_pkg::CNT_W-1:0]        cfg_data
);
	lpht_pkg::status_t            st;
	logic [lpht_pkg::IDX_W-1:0]   rslot;
	logic [lpht_pkg::KEY_W-1:0]   rkey;
	logic [lpht_pkg::CNT_W-1:0]   used;
	logic                         idle;

	// cfg wins over a waiting request when idle
	lpht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.req_valid(s_axis_tvalid), .req_ready(idle),
		.req_action(lpht_pkg::action_t'(s_axis_tdata[2:0])),
		.req_key(s_axis_tdata[34:3]), .req_hash(s_axis_tdata[66:35]),
		.req_slot(s_axis_tdata[74:67]),
		.rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready),
		.rsp_status(st), .rsp_slot(rslot), .rsp_key(rkey), .rsp_used(used));

	assign s_axis_tready = idle;
	assign m_axis_tdata  = {{(lpht_pkg::OUT_BYTES_W - lpht_pkg::OUT_W){1'b0}},
		used, rkey, rslot, st};
endmodule

[hw/rtl/lpht_checker.sv]
// Port-level assertions for the hash table, bound to the top level.
`timescale 1ns / 1ps
module lpht_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [lpht_pkg::OUT_BYTES_W-1:0] m_axis_tdata,
	input logic                             cfg_valid,
	input logic                             cfg_ready
);
	// one request in flight: no accept while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(s_axis_tvalid && s_axis_tready))
		else $error("accept while result pending");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[51:43] <= 9'd256) else $error("count range");
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_axis_tready) else $error("no clear pass");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4) else $error("bad status");
endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready));
